// ===== rtl/core/ptd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ptd_pkg;

  localparam int NUM_TASKS = 4;
  localparam int SLOT_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

  localparam int CMD_W = 2;
  localparam int TASK_IDX_W = 4;
  localparam int COUNT_W = 3;
  localparam int TIME_W = 32;
  localparam int OUT_IDX_W = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SCAN    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ENABLE  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_DISABLE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_TASK_COUNT = 3'd0;
  localparam int REG_PERIOD_BASE = 1;

  localparam logic [COUNT_W-1:0] TASK_COUNT_RESET = 3'd4;
  localparam logic [TIME_W-1:0] PERIOD_RESET = 32'd1;

  typedef struct packed {
    logic              eval;
    logic [SLOT_W-1:0] eval_idx;
    logic              emit;
  } ptd_cmd_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               out_free;
    logic               final_item;
  } ptd_status_t;

endpackage
`default_nettype wire

// ===== rtl/core/ptd_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ptd_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  input  wire logic [ptd_pkg::CMD_W-1:0]     command,
  input  wire ptd_pkg::ptd_status_t          status,
  output ptd_pkg::ptd_cmd_t                  cmd,
  output logic                               in_stall
);
  import ptd_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EVAL = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic [SLOT_W-1:0] slot;
  logic [SLOT_W-1:0] slot_next;
  logic accept;
  logic last_slot;

  assign in_stall = (state != ST_IDLE);
  assign accept = in_valid && !in_stall;
  assign last_slot = (COUNT_W'(slot) == (status.count - COUNT_W'(1)));

  assign cmd.eval = (state == ST_EVAL);
  assign cmd.eval_idx = slot;
  assign cmd.emit = (state == ST_EMIT);

  always_comb begin
    state_next = state;
    slot_next = slot;
    case (state)
      ST_IDLE: begin
        if (accept && command == CMD_SCAN) begin
          slot_next = '0;
          state_next = (status.count == '0) ? ST_EMIT : ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (last_slot) begin
          state_next = ST_EMIT;
        end else begin
          slot_next = slot + SLOT_W'(1);
        end
      end
      ST_EMIT: begin
        if (status.out_free && status.final_item) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      slot <= '0;
    end else begin
      state <= state_next;
      slot <= slot_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/ptd_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ptd_datapath (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              accept,
  input  wire logic [ptd_pkg::CMD_W-1:0]         command,
  input  wire logic [ptd_pkg::TASK_IDX_W-1:0]    task_index,
  input  wire logic                              run_now,
  input  wire logic                              cfg_write,
  input  wire logic [ptd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [ptd_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire ptd_pkg::ptd_cmd_t                 cmd,
  output ptd_pkg::ptd_status_t                   status,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   fired,
  output logic [ptd_pkg::OUT_IDX_W-1:0]          fired_index,
  output logic [ptd_pkg::TIME_W-1:0]             fire_time,
  output logic                                   last_of_scan
);
  import ptd_pkg::*;

  logic [COUNT_W-1:0] task_count;
  logic [TIME_W-1:0] period [NUM_TASKS];
  logic [TIME_W-1:0] tick_count;
  logic [NUM_TASKS-1:0] slot_active;
  logic [TIME_W-1:0] last_fire_time [NUM_TASKS];
  logic [NUM_TASKS-1:0] due_mask;

  logic [COUNT_W-1:0] count;
  logic idx_ok;
  logic [SLOT_W-1:0] idx;
  logic [TIME_W-1:0] elapsed;
  logic due;
  logic [SLOT_W-1:0] sel;
  logic load;

  assign count = (task_count > COUNT_W'(NUM_TASKS)) ? COUNT_W'(NUM_TASKS) : task_count;
  assign idx_ok = (task_index < TASK_IDX_W'(count));
  assign idx = task_index[SLOT_W-1:0];

  // one elapsed-time compare shared by all slots
  assign elapsed = tick_count - last_fire_time[cmd.eval_idx];
  assign due = slot_active[cmd.eval_idx] && (elapsed >= period[cmd.eval_idx]);

  always_comb begin
    sel = '0;
    for (int i = NUM_TASKS - 1; i >= 0; i--) begin
      if (due_mask[i]) begin
        sel = SLOT_W'(i);
      end
    end
  end

  assign status.count = count;
  assign status.out_free = !out_valid || !out_stall;
  assign status.final_item = ((due_mask & (due_mask - NUM_TASKS'(1))) == '0);
  assign load = cmd.emit && status.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      task_count <= TASK_COUNT_RESET;
      for (int i = 0; i < NUM_TASKS; i++) begin
        period[i] <= PERIOD_RESET;
      end
    end else if (cfg_write) begin
      if (cfg_index == REG_TASK_COUNT) begin
        task_count <= cfg_data[COUNT_W-1:0];
      end
      for (int i = 0; i < NUM_TASKS; i++) begin
        if (cfg_index == CFG_IDX_W'(REG_PERIOD_BASE + i)) begin
          period[i] <= cfg_data[TIME_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
      slot_active <= '0;
      for (int i = 0; i < NUM_TASKS; i++) begin
        last_fire_time[i] <= '0;
      end
    end else if (accept) begin
      case (command)
        CMD_TICK: begin
          tick_count <= tick_count + TIME_W'(1);
        end
        CMD_ENABLE: begin
          if (idx_ok) begin
            slot_active[idx] <= 1'b1;
            last_fire_time[idx] <= run_now ? (tick_count - period[idx]) : tick_count;
          end
        end
        CMD_DISABLE: begin
          if (idx_ok) begin
            slot_active[idx] <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end else if (cmd.eval && due) begin
      last_fire_time[cmd.eval_idx] <= tick_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      due_mask <= '0;
    end else if (accept && command == CMD_SCAN) begin
      due_mask <= '0;
    end else if (cmd.eval) begin
      due_mask[cmd.eval_idx] <= due;
    end else if (load && due_mask != '0) begin
      due_mask[sel] <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      last_of_scan <= status.final_item;
      if (due_mask == '0) begin
        fired <= 1'b0;
        fired_index <= '0;
        fire_time <= '0;
      end else begin
        fired <= 1'b1;
        fired_index <= OUT_IDX_W'(sel);
        fire_time <= tick_count;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/periodic_task_dispatcher.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Periodic task dispatcher: a 32-bit wrapping tick counter plus NUM_TASKS task slots, each with
// an active flag and a last-fire time. Tick, enable and disable items do not stall the input. A
// scan visits the N slots in use and then gives R results (at least one, an empty scan giving a
// single result with fired low). A single elapsed-time subtract and compare visits one slot per
// cycle, and the due slots are then sent out one per cycle, while the output is not stalled,
// through the output register. Input is stalled until the last result of a scan is in the output
// register. Configuration is written through cfg_write/cfg_index/cfg_data: index 0 task_count,
// indexes 1 to 4 the periods.
module periodic_task_dispatcher (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [ptd_pkg::CMD_W-1:0]         command,
  input  wire logic [ptd_pkg::TASK_IDX_W-1:0]    task_index,
  input  wire logic                              run_now,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   fired,
  output logic [ptd_pkg::OUT_IDX_W-1:0]          fired_index,
  output logic [ptd_pkg::TIME_W-1:0]             fire_time,
  output logic                                   last_of_scan,
  input  wire logic                              cfg_write,
  input  wire logic [ptd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [ptd_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import ptd_pkg::*;

  ptd_cmd_t cmd;
  ptd_status_t status;
  logic accept;

  assign accept = in_valid && !in_stall;

  ptd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .command  (command),
    .status   (status),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  ptd_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .command      (command),
    .task_index   (task_index),
    .run_now      (run_now),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .fired        (fired),
    .fired_index  (fired_index),
    .fire_time    (fire_time),
    .last_of_scan (last_of_scan)
  );

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !fired |-> last_of_scan)
    else $error("empty scan result not marked last");

  a_idle_holds_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !in_stall |-> last_of_scan)
    else $error("input taken while a scan is still sending results");

  a_scan_stalls: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && command == CMD_SCAN |=> in_stall)
    else $error("scan item did not stall the input");

endmodule
`default_nettype wire
